@@ src/local_directional_number_code_assert.svh @@
// Assertion macros shared by the checker of the directional number code block.
`ifndef LOCAL_DIRECTIONAL_NUMBER_CODE_ASSERT_SVH
`define LOCAL_DIRECTIONAL_NUMBER_CODE_ASSERT_SVH

// Property checked on every rising edge while out of reset.
`define LDNC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that also has to hold while reset is applied.
`define LDNC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ldnc_pkg.sv @@
// Types and constants shared by the directional number code block.
`timescale 1ns / 1ps
package ldnc_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 5;
  localparam int WIN_TAPS   = 9;
  localparam int WIN_COLS   = 3;
  localparam int MASK_COUNT = 8;
  localparam int IDX_W      = 3;
  localparam int MASK_W     = COEF_W * WIN_TAPS;
  localparam int CODE_W     = 2 * IDX_W;
  localparam int CFG_IDX_W  = 3;
  // Nine taps of a signed 5-bit coefficient times an 8-bit pixel fit in 17 bits.
  localparam int RESP_W     = 17;
  localparam int ROW_W      = 2;
  localparam logic [ROW_W-1:0] ROW_FULL = 2'd2;

  // Output queue depth and the number of pipeline stages an item may sit in.
  localparam int OQ_DEPTH   = 8;
  localparam int OQ_PTR_W   = 3;
  localparam int OQ_CNT_W   = 4;
  localparam int PIPE_STAGES = 5;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
    logic             line_end;
  } ldnc_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] direction_code;
    logic              row_last;
  } ldnc_out_t;

  // Window taps, index row*3+column, row 0 is the oldest row.
  typedef logic [WIN_TAPS-1:0][PIX_W-1:0] ldnc_win_t;

  // Control that travels alongside a transaction through the pipeline.
  typedef struct packed {
    logic valid;
    logic row_last;
  } ldnc_ctl_t;

  // Product of one signed coefficient with one unsigned pixel.
  function automatic logic signed [RESP_W-1:0] ldnc_tap(input logic [COEF_W-1:0] cf,
                                                        input logic [PIX_W-1:0]  px);
    logic signed [RESP_W-1:0] a;
    logic signed [RESP_W-1:0] b;
    a = RESP_W'($signed(cf));
    b = RESP_W'($signed({1'b0, px}));
    return RESP_W'(a * b);
  endfunction

endpackage

@@ src/ldnc_line_buf.sv @@
// Line stores, column and row counters, and the 3x3 window.
`timescale 1ns / 1ps
module ldnc_line_buf
  import ldnc_pkg::*;
#(
  parameter int LINE_WIDTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  ldnc_in_t  in_item,
  output ldnc_win_t win_r,
  output ldnc_ctl_t s1_ctl,
  output ldnc_ctl_t s2_ctl_r
);

  localparam int ADDR_W = $clog2(LINE_WIDTH);
  localparam logic [ADDR_W-1:0] COL_MAX = ADDR_W'(LINE_WIDTH - 1);

  logic [PIX_W-1:0] store_a [LINE_WIDTH];
  logic [PIX_W-1:0] store_b [LINE_WIDTH];

  logic [ADDR_W-1:0] col_r, col_nxt, col_eff;
  logic [ROW_W-1:0]  row_r, row_nxt, row_eff;
  logic              prod;

  logic              s1_v_r;
  logic              s1_prod_r;
  logic              s1_le_r;
  logic [ADDR_W-1:0] s1_col_r;
  logic [PIX_W-1:0]  s1_px_r;
  logic [PIX_W-1:0]  rd_a_r, rd_b_r;
  logic              fwd_hit_r;
  logic [PIX_W-1:0]  fwd_a_r, fwd_b_r;
  logic [PIX_W-1:0]  mid, top;
  ldnc_win_t         win_nxt;

  // Position of the accepted pixel; a frame start clears both counts first.
  always_comb begin
    col_eff = in_item.frame_start ? '0 : col_r;
    row_eff = in_item.frame_start ? '0 : row_r;
    prod    = (row_eff >= ROW_FULL) && (col_eff >= ADDR_W'(2));
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (in_item.line_end) begin
        col_nxt = '0;
        row_nxt = (row_eff < ROW_FULL) ? row_eff + ROW_W'(1) : row_eff;
      end else begin
        col_nxt = (col_eff < COL_MAX) ? col_eff + ADDR_W'(1) : col_eff;
        row_nxt = row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
      s2_ctl_r <= '0;
    end else begin
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      s1_v_r         <= acc;
      s2_ctl_r.valid <= s1_v_r && s1_prod_r;
      s2_ctl_r.row_last <= s1_le_r;
    end
  end

  // Stage one payload, captured with the read of both stores.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_prod_r <= prod;
      s1_le_r   <= in_item.line_end;
      s1_col_r  <= col_eff;
      s1_px_r   <= in_item.pixel;
      // The previous transaction writes this entry at the same edge: forward it.
      fwd_hit_r <= s1_v_r && (s1_col_r == col_eff);
      fwd_a_r   <= s1_px_r;
      fwd_b_r   <= mid;
    end
  end

  // Store memories: one read on acceptance, one write-back in stage one.
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_a_r <= store_a[col_eff];
      rd_b_r <= store_b[col_eff];
    end
    if (s1_v_r) begin
      store_a[s1_col_r] <= s1_px_r;
      store_b[s1_col_r] <= mid;
    end
  end

  assign mid = fwd_hit_r ? fwd_a_r : rd_a_r;
  assign top = fwd_hit_r ? fwd_b_r : rd_b_r;

  // Window shifts one column left and takes the new column on the right.
  always_comb begin
    win_nxt = win_r;
    for (int r = 0; r < WIN_COLS; r++) begin
      win_nxt[r*WIN_COLS]     = win_r[r*WIN_COLS + 1];
      win_nxt[r*WIN_COLS + 1] = win_r[r*WIN_COLS + 2];
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_v_r) begin
      win_r <= win_nxt;
    end
  end

  assign s1_ctl.valid    = s1_v_r;
  assign s1_ctl.row_last = s1_le_r;

endmodule

@@ src/ldnc_resp.sv @@
// Eight directional mask responses over the window, in two registered stages.
`timescale 1ns / 1ps
module ldnc_resp
  import ldnc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ldnc_win_t                win,
  input  ldnc_ctl_t                ctl_in,
  input  logic [MASK_W-1:0]        masks [MASK_COUNT],
  output logic signed [RESP_W-1:0] resp_r [MASK_COUNT],
  output ldnc_ctl_t                ctl_a_r,
  output ldnc_ctl_t                ctl_r
);

  logic signed [RESP_W-1:0] row_sum_r [MASK_COUNT][WIN_COLS];
  logic signed [RESP_W-1:0] row_sum_nxt [MASK_COUNT][WIN_COLS];
  logic signed [RESP_W-1:0] resp_nxt [MASK_COUNT];

  // First stage: three taps per window row for every mask lane.
  always_comb begin
    for (int m = 0; m < MASK_COUNT; m++) begin
      for (int r = 0; r < WIN_COLS; r++) begin
        row_sum_nxt[m][r] =
          ldnc_tap(masks[m][COEF_W*(r*WIN_COLS)     +: COEF_W], win[r*WIN_COLS]) +
          ldnc_tap(masks[m][COEF_W*(r*WIN_COLS + 1) +: COEF_W], win[r*WIN_COLS + 1]) +
          ldnc_tap(masks[m][COEF_W*(r*WIN_COLS + 2) +: COEF_W], win[r*WIN_COLS + 2]);
      end
    end
  end

  // Second stage: add the three row sums of each lane.
  always_comb begin
    for (int m = 0; m < MASK_COUNT; m++) begin
      resp_nxt[m] = row_sum_r[m][0] + row_sum_r[m][1] + row_sum_r[m][2];
    end
  end

  always_ff @(posedge clk) begin
    row_sum_r <= row_sum_nxt;
    resp_r    <= resp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_r   <= '0;
    end else begin
      ctl_a_r <= ctl_in;
      ctl_r   <= ctl_a_r;
    end
  end

endmodule

@@ src/ldnc_argext.sv @@
// Strongest and weakest direction by a compare tree, lowest index on ties.
`timescale 1ns / 1ps
module ldnc_argext
  import ldnc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [RESP_W-1:0] resp [MASK_COUNT],
  input  ldnc_ctl_t                ctl_in,
  output ldnc_out_t                res_r,
  output logic                     res_v_r
);

  logic signed [RESP_W-1:0] mx_v [2*MASK_COUNT-1];
  logic signed [RESP_W-1:0] mn_v [2*MASK_COUNT-1];
  logic [IDX_W-1:0]         mx_i [2*MASK_COUNT-1];
  logic [IDX_W-1:0]         mn_i [2*MASK_COUNT-1];

  // Leaves sit at MASK_COUNT-1 upwards; node n has children 2n+1 and 2n+2.
  // The left child always holds the lower indices, so it wins when equal.
  always_comb begin
    for (int m = 0; m < MASK_COUNT; m++) begin
      mx_v[MASK_COUNT-1+m] = resp[m];
      mn_v[MASK_COUNT-1+m] = resp[m];
      mx_i[MASK_COUNT-1+m] = IDX_W'(m);
      mn_i[MASK_COUNT-1+m] = IDX_W'(m);
    end
    for (int n = MASK_COUNT - 2; n >= 0; n--) begin
      if (mx_v[2*n+2] > mx_v[2*n+1]) begin
        mx_v[n] = mx_v[2*n+2];
        mx_i[n] = mx_i[2*n+2];
      end else begin
        mx_v[n] = mx_v[2*n+1];
        mx_i[n] = mx_i[2*n+1];
      end
      if (mn_v[2*n+2] < mn_v[2*n+1]) begin
        mn_v[n] = mn_v[2*n+2];
        mn_i[n] = mn_i[2*n+2];
      end else begin
        mn_v[n] = mn_v[2*n+1];
        mn_i[n] = mn_i[2*n+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r.direction_code <= {mx_i[0], mn_i[0]};
    res_r.row_last       <= ctl_in.row_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else begin
      res_v_r <= ctl_in.valid;
    end
  end

endmodule

@@ src/ldnc_out_fifo.sv @@
// Output queue that decouples the pipeline from the result channel.
`timescale 1ns / 1ps
module ldnc_out_fifo
  import ldnc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ldnc_out_t           push_data,
  input  logic                pop,
  output logic                not_empty,
  output ldnc_out_t           head,
  output logic [OQ_CNT_W-1:0] count_r
);

  ldnc_out_t             mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + OQ_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - OQ_CNT_W'(1);
      end
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

endmodule

@@ src/local_directional_number_code.sv @@
// Path: stage one, window register, two response stages, compare register, output queue.
// Throughput: one pixel per cycle; in_stall rises only once the 8-entry output queue
// together with the 5 pipeline stages holds 8 transactions, i.e. under output back-pressure.
// Reset (synchronous, rst_n low): clears counters, window, pipeline, queue and masks.
// The line stores are not cleared and hold no data until a row has been written.
`timescale 1ns / 1ps
module local_directional_number_code
  import ldnc_pkg::*;
#(
  parameter int LINE_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ldnc_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ldnc_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_wdata
);

  logic [MASK_W-1:0]        mask_r [MASK_COUNT];
  logic                     acc;
  ldnc_win_t                win;
  ldnc_ctl_t                s1_ctl, s2_ctl, s3_ctl, s4_ctl;
  logic signed [RESP_W-1:0] resp [MASK_COUNT];
  ldnc_out_t                res;
  logic                     res_v;
  logic                     pop;
  logic [OQ_CNT_W-1:0]      oq_count;
  logic [OQ_CNT_W:0]        reserved;

  // Mask registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < MASK_COUNT; m++) begin
        mask_r[m] <= '0;
      end
    end else if (cfg_we) begin
      mask_r[cfg_index] <= cfg_wdata;
    end
  end

  // Admission: every transaction in flight has a queue entry reserved for it.
  assign reserved = (OQ_CNT_W+1)'(oq_count) + (OQ_CNT_W+1)'(s1_ctl.valid)
                  + (OQ_CNT_W+1)'(s2_ctl.valid) + (OQ_CNT_W+1)'(s3_ctl.valid)
                  + (OQ_CNT_W+1)'(s4_ctl.valid) + (OQ_CNT_W+1)'(res_v);
  assign in_stall = (reserved >= (OQ_CNT_W+1)'(OQ_DEPTH));
  assign acc      = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  ldnc_line_buf #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_item (in_data),
    .win_r   (win),
    .s1_ctl  (s1_ctl),
    .s2_ctl_r(s2_ctl)
  );

  ldnc_resp u_resp (
    .clk    (clk),
    .rst_n  (rst_n),
    .win    (win),
    .ctl_in (s2_ctl),
    .masks  (mask_r),
    .resp_r (resp),
    .ctl_a_r(s3_ctl),
    .ctl_r  (s4_ctl)
  );

  ldnc_argext u_argext (
    .clk    (clk),
    .rst_n  (rst_n),
    .resp   (resp),
    .ctl_in (s4_ctl),
    .res_r  (res),
    .res_v_r(res_v)
  );

  ldnc_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_v),
    .push_data(res),
    .pop      (pop),
    .not_empty(out_valid),
    .head     (out_data),
    .count_r  (oq_count)
  );

endmodule

@@ src/ldnc_checker.sv @@
// Port-level checker for the directional number code block, bound to the top level.
`timescale 1ns / 1ps
`include "local_directional_number_code_assert.svh"
module ldnc_checker
  import ldnc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input ldnc_out_t out_data
);

  // A stalled result stays offered and unchanged.
  `LDNC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `LDNC_ASSERT(a_out_data, out_valid && out_stall |=> $stable(out_data), "stalled result changed")

  // Reset empties the output queue.
  `LDNC_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result offered after reset")

  // A result that appears on an empty channel comes from a transaction accepted earlier.
  `LDNC_ASSERT(a_latency, $rose(out_valid) |-> $past(in_valid && !in_stall, 6), "result without matching transaction")

  // The input only stalls while results are backing up.
  `LDNC_ASSERT(a_stall_cause, in_stall |-> out_valid, "input stalled with no pending result")

endmodule

bind local_directional_number_code ldnc_checker u_ldnc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the local directional number code block.
`timescale 1ns / 1ps
module tb_top;
  import ldnc_pkg::*;

  localparam int LINE_W       = 1024;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_LEN   = PIPE_STAGES + 7;
  localparam int PHASE_PIXELS = 200;
  localparam int HOLD_LEN     = 300;

  localparam logic [CFG_IDX_W-1:0] REG_MASK_DIR0 = 3'd0;
  localparam logic [COEF_W-1:0]    COEF_MIN      = 5'b10000;
  localparam logic [COEF_W-1:0]    COEF_MAX      = 5'b01111;

  typedef enum int {PAT_RANDOM, PAT_WHITE, PAT_BLACK, PAT_CHECKER} pix_pat_e;
  typedef enum int {MS_RANDOM, MS_SMALL, MS_EXTREME} mask_style_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  ldnc_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  ldnc_out_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MASK_DIR0;
  logic [MASK_W-1:0]    cfg_wdata = '0;
  logic                 hold_active = 1'b0;

  // Pixels waiting to be offered and direction codes waiting to be returned.
  ldnc_in_t  pending_pixels [$];
  ldnc_out_t expected_codes [$];

  // Shadow copy of the block's state used to predict each direction code.
  logic [MASK_W-1:0] dir_mask [MASK_COUNT];
  logic [PIX_W-1:0]  prev_row [LINE_W];
  logic [PIX_W-1:0]  older_row [LINE_W];
  logic [PIX_W-1:0]  win [WIN_TAPS];
  int                col_cnt;
  int                row_cnt;

  // Stimulus bookkeeping: defined prefix of each line store, rows seen in the frame.
  int gen_rows  = 0;
  int gen_a_len = 0;
  int gen_b_len = 0;
  bit gen_open  = 1'b0;
  int pushed    = 0;

  int code_errors = 0;
  int codes_seen  = 0;
  int cycle_cnt   = 0;

  local_directional_number_code #(.LINE_WIDTH(LINE_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Idle length between transactions: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Dot product of the current window with one packed mask.
  function automatic int mask_response(input logic [MASK_W-1:0] m);
    int k;
    int cf;
    int px;
    int acc;
    acc = 0;
    for (k = 0; k < WIN_TAPS; k++) begin
      cf = $signed(m[COEF_W*k +: COEF_W]);
      px = win[k];
      acc += cf * px;
    end
    return acc;
  endfunction

  // Advance the shadow state by one accepted pixel and queue any code it yields.
  task automatic predict_direction_code(input ldnc_in_t t);
    int c;
    int r;
    int v;
    int acc;
    int best_v;
    int low_v;
    int best_i;
    int low_i;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    ldnc_out_t res;
    if (t.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = (col_cnt > LINE_W - 1) ? LINE_W - 1 : col_cnt;
    top = older_row[c];
    mid = prev_row[c];
    older_row[c] = mid;
    prev_row[c] = t.pixel;
    for (r = 0; r < WIN_COLS; r++) begin
      win[r*3]     = win[r*3 + 1];
      win[r*3 + 1] = win[r*3 + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = t.pixel;
    if (row_cnt >= ROW_FULL && c >= 2) begin
      best_i = 0;
      low_i  = 0;
      best_v = mask_response(dir_mask[0]);
      low_v  = best_v;
      // Strict comparisons keep the lowest index on a tie.
      for (v = 1; v < MASK_COUNT; v++) begin
        acc = mask_response(dir_mask[v]);
        if (acc > best_v) begin
          best_v = acc;
          best_i = v;
        end
        if (acc < low_v) begin
          low_v = acc;
          low_i = v;
        end
      end
      res.direction_code = {IDX_W'(best_i), IDX_W'(low_i)};
      res.row_last = t.line_end;
      expected_codes.push_back(res);
    end
    if (t.line_end) begin
      col_cnt = 0;
      if (row_cnt < ROW_FULL) row_cnt++;
    end else if (c < LINE_W - 1) begin
      col_cnt = c + 1;
    end else begin
      col_cnt = c;
    end
  endtask

  // Queue one row of pixels. A row that would produce codes is trimmed so that
  // it never reaches a line store entry that has not yet been written.
  task automatic push_row(input int len, input bit fs, input bit le, input pix_pat_e pat);
    int n;
    int k;
    int used;
    ldnc_in_t t;
    if (gen_open) fs = 1'b1;
    if (fs) gen_rows = 0;
    n = len;
    if (gen_rows >= 2 && n >= 3 && gen_b_len < LINE_W && n > gen_b_len)
      n = (gen_b_len >= 3) ? gen_b_len : 2;
    for (k = 0; k < n; k++) begin
      case (pat)
        PAT_WHITE:   t.pixel = '1;
        PAT_BLACK:   t.pixel = '0;
        PAT_CHECKER: t.pixel = (k % 2 == 1) ? '1 : '0;
        default:     t.pixel = PIX_W'($urandom_range(0, 255));
      endcase
      t.frame_start = fs && (k == 0);
      t.line_end    = le && (k == n - 1);
      pending_pixels.push_back(t);
    end
    pushed += n;
    used = (n < LINE_W) ? n : LINE_W;
    if (used < gen_a_len && used > gen_b_len) gen_b_len = used;
    else if (gen_a_len > gen_b_len && used >= gen_a_len) gen_b_len = gen_a_len;
    if (used > gen_a_len) gen_a_len = used;
    if (le && gen_rows < 2) gen_rows++;
    gen_open = !le;
  endtask

  // Mostly well-formed frames of random content, with odd rows, cut rows and
  // frames that carry on without a frame start mixed in.
  task automatic push_random_frames(input int count);
    int stop;
    int w;
    int rows;
    int r;
    int len;
    int pick;
    bit fs;
    bit le;
    stop = pushed + count;
    while (pushed < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) w = $urandom_range(1, 2);
      else if (pick < 88) w = $urandom_range(3, 10);
      else w = $urandom_range(11, 48);
      rows = $urandom_range(2, 7);
      fs = ($urandom_range(0, 19) != 0);
      for (r = 0; r < rows; r++) begin
        len = w;
        if ($urandom_range(0, 19) == 0) len = $urandom_range(1, w + 3);
        le = !(r == rows - 1 && $urandom_range(0, 9) == 0);
        push_row(len, fs && r == 0, le, PAT_RANDOM);
      end
    end
  endtask

  function automatic logic [MASK_W-1:0] make_mask(input mask_style_e style);
    logic [MASK_W-1:0] m;
    int k;
    int cf;
    m = MASK_W'({$urandom, $urandom});
    for (k = 0; k < WIN_TAPS; k++) begin
      case (style)
        MS_SMALL: begin
          cf = $urandom_range(0, 2) - 1;
          m[COEF_W*k +: COEF_W] = COEF_W'(cf);
        end
        MS_EXTREME: m[COEF_W*k +: COEF_W] = ($urandom_range(0, 1) == 1) ? COEF_MIN : COEF_MAX;
        default: ;
      endcase
    end
    return m;
  endfunction

  // Write every mask register from the shadow copy, one per clock.
  task automatic write_masks();
    int v;
    for (v = 0; v < MASK_COUNT; v++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= REG_MASK_DIR0 + CFG_IDX_W'(v);
      cfg_wdata <= dir_mask[v];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every pixel has gone in and every code has come out, then let
  // pixels that give no code clear the pipeline.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_codes.size() != 0);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  task automatic run_phase(input mask_style_e style, input bit same, input bit wide);
    int v;
    for (v = 0; v < MASK_COUNT; v++)
      dir_mask[v] = (same && v > 0) ? dir_mask[0] : make_mask(style);
    write_masks();
    push_random_frames(PHASE_PIXELS);
    // One frame wider than the line stores, so the column count saturates.
    if (wide) begin
      push_row(LINE_W, 1'b1, 1'b1, PAT_RANDOM);
      push_row(LINE_W, 1'b0, 1'b1, PAT_RANDOM);
      push_row(LINE_W + 3, 1'b0, 1'b1, PAT_RANDOM);
    end
    wait_drained();
  endtask

  // Source side: offers queued pixels with random gaps between transactions.
  always @(posedge clk) begin : drive_pixels
    int  drv_gap;
    int  drv_calm;
    logic fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      drv_gap  = 0;
      drv_calm = 0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) predict_direction_code(in_data);
      if (in_valid && !fire) begin
        // Stalled: hold the transaction as it is.
      end else if (drv_gap > 0) begin
        drv_gap--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_pixels.pop_front();
        if (drv_calm > 0) begin
          drv_calm--;
          drv_gap = 0;
        end else begin
          drv_gap = pick_gap();
          if ($urandom_range(0, 63) == 0) drv_calm = $urandom_range(20, 80);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in cycles, while pixels keep arriving.
  always @(posedge clk) begin : hold_off
    int hold_left;
    int holds_done;
    int next_hold_at;
    if (!rst_n) begin
      hold_active  <= 1'b0;
      hold_left    = 0;
      holds_done   = 0;
      next_hold_at = 60;
    end else begin
      if (holds_done < 2 && hold_left == 0 && codes_seen >= next_hold_at &&
          pending_pixels.size() > 40) begin
        hold_left    = HOLD_LEN;
        holds_done++;
        next_hold_at = codes_seen + 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        hold_active <= 1'b1;
      end else begin
        hold_active <= 1'b0;
      end
    end
  end

  // Sink side: checks each returned code and stalls at random.
  always @(posedge clk) begin : sink_codes
    int snk_gap;
    int snk_calm;
    ldnc_out_t want;
    if (!rst_n) begin
      out_stall    <= 1'b1;
      snk_gap      = 0;
      snk_calm     = 0;
    end else begin
      if (out_valid && !out_stall) begin
        codes_seen++;
        if (expected_codes.size() == 0) begin
          $display("%0t: unexpected code, expected none, got %0d row_last %0b",
                   $time, out_data.direction_code, out_data.row_last);
          code_errors++;
        end else begin
          want = expected_codes.pop_front();
          if (out_data.direction_code !== want.direction_code) begin
            $display("%0t: direction_code expected %0d got %0d",
                     $time, want.direction_code, out_data.direction_code);
            code_errors++;
          end
          if (out_data.row_last !== want.row_last) begin
            $display("%0t: row_last expected %0b got %0b",
                     $time, want.row_last, out_data.row_last);
            code_errors++;
          end
        end
      end
      if (hold_active) begin
        out_stall <= 1'b1;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (snk_calm > 0) begin
          snk_calm--;
          snk_gap = 0;
        end else begin
          snk_gap = pick_gap();
          if ($urandom_range(0, 63) == 0) snk_calm = $urandom_range(20, 80);
        end
      end
    end
  end

  // Watchdog against a hung pipeline.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : run_test
    int k;
    for (k = 0; k < LINE_W; k++) begin
      prev_row[k]  = '0;
      older_row[k] = '0;
    end
    for (k = 0; k < WIN_TAPS; k++) win[k] = '0;
    for (k = 0; k < MASK_COUNT; k++) dir_mask[k] = '0;
    col_cnt = 0;
    row_cnt = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Masks still at reset: every response ties, so each code is zero.
    push_row(4, 1'b1, 1'b1, PAT_WHITE);
    push_row(4, 1'b0, 1'b1, PAT_BLACK);
    push_row(4, 1'b0, 1'b1, PAT_CHECKER);
    wait_drained();

    // Extreme coefficients, a one-pixel row, and a frame start cutting a row short.
    dir_mask[0] = {WIN_TAPS{COEF_MIN}};
    dir_mask[1] = {WIN_TAPS{COEF_MAX}};
    for (k = 2; k < MASK_COUNT; k++) dir_mask[k] = make_mask(MS_RANDOM);
    write_masks();
    push_row(1, 1'b1, 1'b1, PAT_WHITE);
    push_row(2, 1'b0, 1'b0, PAT_CHECKER);
    push_row(3, 1'b1, 1'b1, PAT_WHITE);
    push_row(3, 1'b0, 1'b1, PAT_BLACK);
    push_row(3, 1'b0, 1'b1, PAT_CHECKER);
    wait_drained();

    // Random frames under a range of mask settings.
    run_phase(MS_RANDOM, 1'b0, 1'b0);
    run_phase(MS_RANDOM, 1'b1, 1'b0);
    run_phase(MS_SMALL, 1'b0, 1'b0);
    run_phase(MS_EXTREME, 1'b0, 1'b0);
    run_phase(MS_RANDOM, 1'b0, 1'b0);

    if (code_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
